// File: rtl/core/lref_pkg.sv
// ----------------------------------------------------------------------------
// lref_pkg
// Shared types, register indexes and helpers for the LED ring effect frame
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lref_pkg;

	localparam int MAX_LEDS_DEF = 64;
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 24;
	localparam int COMET_LEN    = 6;
	localparam int TRAIL_STEP   = 40;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_COLOR  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER      = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE   = 8'd3;

	typedef enum logic [1:0] {
		STYLE_BLINK  = 2'd0,
		STYLE_RIPPLE = 2'd1,
		STYLE_SPIN   = 2'd2,
		STYLE_FILL   = 2'd3
	} style_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_DIV,
		FS_PLOAD,
		FS_PHASE,
		FS_MUL,
		FS_HOLD
	} setup_state_t;

	// per-frame parameters handed from setup to the pixel pipeline
	typedef struct packed {
		style_t      style;
		logic        blink_on;
		logic [5:0]  radius;
		logic [5:0]  head;
		logic [6:0]  count;
		logic [5:0]  center;
		logic [6:0]  n;
	} frame_t;

	// brightness of comet trail position t (t below the comet length)
	function automatic logic [7:0] trail_scale(input logic [2:0] t);
		return 8'(255 - TRAIL_STEP * int'(t));
	endfunction

	// floor(x / 255) for x below 2^14
	function automatic logic [6:0] div255(input logic [13:0] x);
		logic [14:0] s;
		s = 15'(x) + 15'(x[13:8]) + 15'd1;
		return s[14:8];
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/lref_intf.sv
// ----------------------------------------------------------------------------
// lref_intf
// Valid/ready channel interfaces: frame request, LED color and config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface lref_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  style;
	logic [31:0] elapsed_ms;
	modport source (output valid, style, elapsed_ms, input ready);
	modport sink   (input valid, style, elapsed_ms, output ready);
endinterface

interface lref_pix_if;
	logic       valid;
	logic       ready;
	logic [5:0] led_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       last;
	modport source (output valid, led_index, red, green, blue, last, input ready);
	modport sink   (input valid, led_index, red, green, blue, last, output ready);
endinterface

interface lref_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [23:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lref_frame_setup.sv
// ----------------------------------------------------------------------------
// lref_frame_setup
// Buffers one request and works out cycle position, phase and the per-style
// frame parameters with a bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module lref_frame_setup import lref_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	lref_req_if.sink    req,
	input  wire  [15:0] half,
	input  wire  [6:0]  n,
	input  wire  [5:0]  center,
	output frame_t      frm,
	output logic        frm_valid,
	input  wire         frm_ready
);

	setup_state_t state_q, state_nx;

	logic        buf_valid_q;
	logic [1:0]  buf_style_q;
	logic [31:0] buf_elapsed_q;

	logic [31:0] dvd_q;
	logic [16:0] rem_q;
	logic [16:0] per_q;
	logic [15:0] half_q;
	logic [6:0]  n_q;
	logic [16:0] in_cycle_q;
	logic [7:0]  phase_q;
	logic [4:0]  cnt_q;
	style_t      style_q;
	logic [5:0]  cen_rem_q;
	logic [5:0]  cen_dvd_q;
	logic [13:0] prod_rad_q;
	logic [13:0] prod_n_q;

	logic [17:0] trial;
	logic        ge;
	logic [16:0] rem_nx;
	logic [6:0]  ctrial;
	logic        cge;
	logic [24:0] pnum;
	logic        take;

	// request buffer
	assign req.ready = !buf_valid_q;
	assign take = (state_q == FS_IDLE) && buf_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			buf_valid_q <= 1'b1;
		end else if (take) begin
			buf_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			buf_style_q   <= req.style;
			buf_elapsed_q <= req.elapsed_ms;
		end
	end

	// one restoring division step
	always_comb begin
		trial  = {rem_q, dvd_q[31]};
		ge     = trial >= {1'b0, per_q};
		rem_nx = ge ? 17'(trial - {1'b0, per_q}) : trial[16:0];
		ctrial = {cen_rem_q, cen_dvd_q[5]};
		cge    = ctrial >= n_q;
		pnum   = 25'({rem_q, 8'd0}) - 25'(rem_q);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and frame output
	always_comb begin
		state_nx  = state_q;
		frm_valid = 1'b0;
		case (state_q)
			FS_IDLE:  if (buf_valid_q) state_nx = FS_DIV;
			FS_DIV:   if (cnt_q == 5'd31) state_nx = FS_PLOAD;
			FS_PLOAD: state_nx = FS_PHASE;
			FS_PHASE: if (cnt_q == 5'd7) state_nx = FS_MUL;
			FS_MUL:   state_nx = FS_HOLD;
			FS_HOLD: begin
				frm_valid = 1'b1;
				if (frm_ready) state_nx = FS_IDLE;
			end
			default:  state_nx = FS_IDLE;
		endcase
	end

	assign frm.style    = style_q;
	assign frm.blink_on = in_cycle_q < {1'b0, half_q};
	assign frm.radius   = 6'(div255(prod_rad_q));
	assign frm.head     = prod_n_q[13:8];
	assign frm.count    = div255(prod_n_q) + 7'd1;
	assign frm.center   = cen_rem_q;
	assign frm.n        = n_q;

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			FS_IDLE: begin
				dvd_q     <= buf_elapsed_q;
				rem_q     <= '0;
				per_q     <= {half, 1'b0};
				half_q    <= half;
				n_q       <= n;
				style_q   <= style_t'(buf_style_q);
				cen_rem_q <= '0;
				cen_dvd_q <= center;
				cnt_q     <= '0;
			end
			FS_DIV: begin
				rem_q <= rem_nx;
				dvd_q <= {dvd_q[30:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q < 5'd6) begin
					cen_rem_q <= cge ? 6'(ctrial - n_q) : ctrial[5:0];
					cen_dvd_q <= {cen_dvd_q[4:0], 1'b0};
				end
			end
			FS_PLOAD: begin
				in_cycle_q <= rem_q;
				rem_q      <= 17'(pnum >> 8);
				cnt_q      <= '0;
				phase_q    <= '0;
				dvd_q      <= {pnum[7:0], 24'd0};
			end
			FS_PHASE: begin
				rem_q   <= rem_nx;
				dvd_q   <= {dvd_q[30:0], 1'b0};
				phase_q <= {phase_q[6:0], ge};
				cnt_q   <= cnt_q + 5'd1;
			end
			FS_MUL: begin
				prod_rad_q <= 14'(phase_q) * 14'(n_q[6:1] + 6'd2);
				prod_n_q   <= 14'(phase_q) * 14'(n_q);
			end
			default: begin
			end
		endcase
	end

	// in_cycle is taken from rem after the last division step
	// (FS_PLOAD reads rem_q before it is reloaded)

endmodule

`default_nettype wire

// File: rtl/core/lref_pixel_pipe.sv
// ----------------------------------------------------------------------------
// lref_pixel_pipe
// Walks the LEDs of one frame through a three stage pipeline and produces
// one dimmed color per cycle unless a low pix.ready stalls it.
// ----------------------------------------------------------------------------
`default_nettype none

module lref_pixel_pipe import lref_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  frame_t      frm,
	input  wire         frm_valid,
	output logic        frm_ready,
	input  wire  [23:0] base_color,
	lref_pix_if.source  pix
);

	logic       busy_q;
	frame_t     cur_q;
	logic [5:0] idx_q;

	logic       adv;
	logic       issue;
	logic       is_last;
	logic       lit;
	logic [7:0] scale;
	logic [5:0] diff;
	logic [6:0] nd;
	logic [6:0] ring_dist;
	logic [6:0] trail;
	logic [6:0] fpos;

	logic        v_s1, v_s2, v_s3;
	logic [5:0]  idx_s1, idx_s2, idx_s3;
	logic        last_s1, last_s2, last_s3;
	logic        lit_s1;
	logic [7:0]  scale_s1;
	logic [15:0] r_s2, g_s2, b_s2;
	logic [7:0]  r_s3, g_s3, b_s3;

	assign adv       = !v_s3 || pix.ready;
	assign issue     = busy_q && adv;
	assign frm_ready = !busy_q;
	assign is_last   = {1'b0, idx_q} == (cur_q.n - 7'd1);

	// frame walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (!busy_q) begin
			if (frm_valid) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end
		end else if (issue) begin
			idx_q <= idx_q + 6'd1;
			if (is_last) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && frm_valid) cur_q <= frm;
	end

	// lit decision and brightness for the current led
	always_comb begin
		diff  = (idx_q > cur_q.center) ? idx_q - cur_q.center : cur_q.center - idx_q;
		nd    = cur_q.n - {1'b0, diff};
		ring_dist = ({1'b0, diff} > nd) ? nd : {1'b0, diff};
		trail = (cur_q.head < idx_q)
			? 7'({1'b0, cur_q.head} + cur_q.n - {1'b0, idx_q})
			: 7'(cur_q.head - idx_q);
		fpos  = (idx_q >= cur_q.center)
			? 7'(idx_q - cur_q.center)
			: 7'({1'b0, idx_q} + cur_q.n - {1'b0, cur_q.center});
		lit   = 1'b0;
		scale = 8'd255;
		case (cur_q.style)
			STYLE_BLINK:  lit = cur_q.blink_on;
			STYLE_RIPPLE: lit = (ring_dist <= {1'b0, cur_q.radius})
				&& (ring_dist + 7'd1 >= {1'b0, cur_q.radius});
			STYLE_SPIN: begin
				lit = trail < 7'(COMET_LEN);
				if (lit) scale = trail_scale(trail[2:0]);
			end
			STYLE_FILL:   lit = fpos < cur_q.count;
			default:      lit = 1'b0;
		endcase
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage payloads: decide, multiply, scale down
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1   <= idx_q;
			last_s1  <= is_last;
			lit_s1   <= lit;
			scale_s1 <= scale;

			idx_s2  <= idx_s1;
			last_s2 <= last_s1;
			r_s2    <= lit_s1 ? 16'(base_color[23:16]) * (16'(scale_s1) + 16'd1) : '0;
			g_s2    <= lit_s1 ? 16'(base_color[15:8]) * (16'(scale_s1) + 16'd1) : '0;
			b_s2    <= lit_s1 ? 16'(base_color[7:0]) * (16'(scale_s1) + 16'd1) : '0;

			idx_s3  <= idx_s2;
			last_s3 <= last_s2;
			r_s3    <= r_s2[15:8];
			g_s3    <= g_s2[15:8];
			b_s3    <= b_s2[15:8];
		end
	end

	assign pix.valid     = v_s3;
	assign pix.led_index = idx_s3;
	assign pix.red       = r_s3;
	assign pix.green     = g_s3;
	assign pix.blue      = b_s3;
	assign pix.last      = last_s3;

endmodule

`default_nettype wire

// File: rtl/core/led_ring_effect_frame.sv
// ----------------------------------------------------------------------------
// led_ring_effect_frame
// Turns a frame request (style, elapsed ms) into one color per ring LED.
// ----------------------------------------------------------------------------
// Channels: req takes a request of style and elapsed_ms; pix returns one
// color per LED, led_index 0 up to ring size minus one, last on the final
// LED; cfg writes base_color, half_period_ms, center_led and ring_size by
// index and is always ready; write it only while no frame is in flight.
// Setup: a 32-step bit-serial divider works out the cycle position and an
// 8-step one the phase. LEDs then leave at one per cycle while pix.ready is
// high, and the next request is set up while the current frame streams out.
// Reset: clears all valids and loads red, 250 ms, center 0, 16 LEDs.
// Stall: a low pix.ready freezes the three stage LED pipeline in place;
// nothing is lost or repeated, and one request waits in a buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module led_ring_effect_frame import lref_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	lref_req_if.sink   req,
	lref_pix_if.source pix,
	lref_cfg_if.sink   cfg
);

	logic [23:0] base_color_q;
	logic [15:0] half_q;
	logic [5:0]  center_q;
	logic [6:0]  ring_q;

	logic [15:0] half_eff;
	logic [6:0]  n_eff;
	frame_t      frm;
	logic        frm_valid;
	logic        frm_ready;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_color_q <= 24'hFF0000;
			half_q       <= 16'd250;
			center_q     <= 6'd0;
			ring_q       <= 7'd16;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BASE_COLOR:  base_color_q <= cfg.data;
				REG_HALF_PERIOD: half_q       <= cfg.data[15:0];
				REG_CENTER:      center_q     <= cfg.data[5:0];
				REG_RING_SIZE:   ring_q       <= cfg.data[6:0];
				default: begin
				end
			endcase
		end
	end

	// zero half period acts as 1 ms, ring size clamped to 1..max
	assign half_eff = (half_q == 16'd0) ? 16'd1 : half_q;
	assign n_eff    = (ring_q == 7'd0) ? 7'd1
		: (ring_q > 7'(MAX_LEDS_DEF)) ? 7'(MAX_LEDS_DEF) : ring_q;

	lref_frame_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.half      (half_eff),
		.n         (n_eff),
		.center    (center_q),
		.frm       (frm),
		.frm_valid (frm_valid),
		.frm_ready (frm_ready)
	);

	lref_pixel_pipe u_pixels (
		.clk        (clk),
		.arst_n     (arst_n),
		.frm        (frm),
		.frm_valid  (frm_valid),
		.frm_ready  (frm_ready),
		.base_color (base_color_q),
		.pix        (pix)
	);

endmodule

`default_nettype wire

// File: rtl/core/lref_checker.sv
// ----------------------------------------------------------------------------
// lref_checker
// Port-level checks on LED ordering, frame accounting and output holding.
// ----------------------------------------------------------------------------
`default_nettype none

module lref_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       req_valid,
	input wire       req_ready,
	input wire       pix_valid,
	input wire       pix_ready,
	input wire       pix_last,
	input wire [5:0] pix_led_index
);

	logic [2:0] pend_q;
	logic [5:0] exp_idx_q;
	logic       req_acc;
	logic       last_acc;

	assign req_acc  = req_valid && req_ready;
	assign last_acc = pix_valid && pix_ready && pix_last;

	// requests not yet finished and expected next led index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			exp_idx_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(req_acc) - 3'(last_acc);
			if (pix_valid && pix_ready) begin
				exp_idx_q <= pix_last ? 6'd0 : exp_idx_q + 6'd1;
			end
		end
	end

	a_idx_order: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> pix_led_index == exp_idx_q)
		else $error("led index out of order");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> pend_q != 3'd0)
		else $error("led color without a pending request");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid)
		else $error("led valid dropped while stalled");

	a_hold_index: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> $stable(pix_led_index) && $stable(pix_last))
		else $error("led payload changed while stalled");

endmodule

bind led_ring_effect_frame lref_checker u_lref_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.pix_valid     (pix.valid),
	.pix_ready     (pix.ready),
	.pix_last      (pix.last),
	.pix_led_index (pix.led_index)
);

`default_nettype wire

// File: tb/led_ring_effect_frame_checker.sv
// ----------------------------------------------------------------------------
// led_ring_effect_frame_checker
// Watches the request, LED color and config channels, predicts the colors of
// every frame and compares each LED record as a whole, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module led_ring_effect_frame_checker import lref_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	lref_req_if         req,
	lref_pix_if         pix,
	lref_cfg_if         cfg,
	output int          fail_count,
	output int          pending_leds,
	output int          led_count,
	output int          frame_count
);

	typedef struct packed {
		logic [5:0] led_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} led_color_t;

	led_color_t expected_leds[$];

	logic [23:0] base_color;
	logic [15:0] half_period;
	logic [5:0]  center_led;
	logic [6:0]  ring_size;

	function automatic logic [7:0] dim(input logic [7:0] ch, input int b);
		return 8'((int'(ch) * (1 + b)) >> 8);
	endfunction

	// predict all LED colors for one frame request
	task automatic predict_frame(input style_t style, input logic [31:0] elapsed);
		int unsigned half, n, ctr, period, in_cycle, phase, radius, head, count, d, idx;
		int unsigned scale[64];
		bit lit[64];
		led_color_t c;
		half = (half_period == 0) ? 1 : half_period;
		n = (ring_size == 0) ? 1 : ((ring_size > 64) ? 64 : ring_size);
		ctr = center_led % n;
		period = 2 * half;
		in_cycle = elapsed % period;
		phase = int'((longint'(in_cycle) * 255) / period);
		for (int i = 0; i < 64; i++) begin
			lit[i] = 0;
			scale[i] = 255;
		end
		case (style)
			STYLE_BLINK: begin
				if (in_cycle < half)
					for (int i = 0; i < n; i++) lit[i] = 1;
			end
			STYLE_RIPPLE: begin
				radius = (phase * (n / 2 + 2)) / 255;
				for (int i = 0; i < n; i++) begin
					d = (i > ctr) ? i - ctr : ctr - i;
					if (d > n - d) d = n - d;
					if (d <= radius && d + 1 >= radius) lit[i] = 1;
				end
			end
			STYLE_SPIN: begin
				head = (phase * n) / 256;
				for (int t = 0; t < COMET_LEN && t < n; t++) begin
					idx = (head + n - t) % n;
					lit[idx] = 1;
					scale[idx] = 255 - t * TRAIL_STEP;
				end
			end
			default: begin
				count = (phase * n) / 255 + 1;
				for (int i = 0; i < count && i < n; i++) lit[(ctr + i) % n] = 1;
			end
		endcase
		for (int i = 0; i < n; i++) begin
			c.led_index = 6'(i);
			c.red   = lit[i] ? dim(base_color[23:16], scale[i]) : 8'd0;
			c.green = lit[i] ? dim(base_color[15:8], scale[i]) : 8'd0;
			c.blue  = lit[i] ? dim(base_color[7:0], scale[i]) : 8'd0;
			c.last  = (i == n - 1);
			expected_leds.push_back(c);
		end
	endtask

	// watch every channel at the rising edge
	always @(posedge clk or negedge arst_n) begin
		led_color_t got, want;
		if (!arst_n) begin
			base_color   <= 24'hFF0000;
			half_period  <= 16'd250;
			center_led   <= 6'd0;
			ring_size    <= 7'd16;
			fail_count   <= 0;
			led_count    <= 0;
			frame_count  <= 0;
			pending_leds <= 0;
			expected_leds.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_BASE_COLOR:  base_color  <= cfg.data;
					REG_HALF_PERIOD: half_period <= cfg.data[15:0];
					REG_CENTER:      center_led  <= cfg.data[5:0];
					REG_RING_SIZE:   ring_size   <= cfg.data[6:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				predict_frame(style_t'(req.style), req.elapsed_ms);
				frame_count <= frame_count + 1;
			end
			if (pix.valid && pix.ready) begin
				got = '{pix.led_index, pix.red, pix.green, pix.blue, pix.last};
				led_count <= led_count + 1;
				if (expected_leds.size() == 0) begin
					$display("%0t: unexpected LED color, got %p", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_leds.pop_front();
					if (got !== want) begin
						$display("%0t: LED mismatch, expected %p, got %p", $time, want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_leds <= expected_leds.size();
		end
	end

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives frame requests at random pacing and config writes through several
// register settings; the checker predicts and compares the LED colors.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import lref_pkg::*;;

	logic clk = 0;
	logic arst_n = 0;
	int   send_idle = 0;
	int   recv_stall = 0;
	int   fail_count, pending_leds, led_count, frame_count;

	lref_req_if req();
	lref_pix_if pix();
	lref_cfg_if cfg();

	led_ring_effect_frame dut (.clk(clk), .arst_n(arst_n), .req(req), .pix(pix), .cfg(cfg));

	led_ring_effect_frame_checker chk (
		.clk(clk), .arst_n(arst_n), .req(req), .pix(pix), .cfg(cfg),
		.fail_count(fail_count), .pending_leds(pending_leds),
		.led_count(led_count), .frame_count(frame_count)
	);

	always #10 clk = ~clk;

	// receiver stalls at random
	initial begin
		pix.ready = 0;
		forever begin
			@(negedge clk);
			pix.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// send one frame request, idling first at random
	task automatic send_request(input style_t style, input logic [31:0] elapsed);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 0;
			@(negedge clk);
		end
		req.valid      <= 1;
		req.style      <= style;
		req.elapsed_ms <= elapsed;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// write one register; set_regs calls it only while no frame is in flight
	task automatic write_reg(input logic [7:0] index, input logic [23:0] data);
		cfg.valid <= 1;
		cfg.index <= index;
		cfg.data  <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 0;
		while (pending_leds != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic set_regs(input logic [23:0] color, input logic [15:0] half,
			input logic [5:0] center, input logic [6:0] ring);
		drain();
		write_reg(REG_BASE_COLOR, color);
		write_reg(REG_HALF_PERIOD, 24'(half));
		write_reg(REG_CENTER, 24'(center));
		write_reg(REG_RING_SIZE, 24'(ring));
		cfg.valid <= 0;
	endtask

	function automatic logic [31:0] rand_elapsed(input logic [15:0] half);
		case ($urandom_range(3))
			0: return $urandom();
			1: return 32'($urandom_range(2 * int'(half) + 1));
			2: return 32'hFFFF_FFFF - $urandom_range(300);
			default: return $urandom_range(100000);
		endcase
	endfunction

	initial begin
		logic [15:0] half;
		logic [6:0]  ring;
		req.valid = 0;
		req.style = 0;
		req.elapsed_ms = 0;
		cfg.valid = 0;
		cfg.index = 0;
		cfg.data = 0;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: reset settings, every style, field extremes
		for (int s = 0; s < 4; s++) begin
			send_request(style_t'(s), 32'd0);
			send_request(style_t'(s), 32'd249);
			send_request(style_t'(s), 32'd250);
			send_request(style_t'(s), 32'hFFFF_FFFF);
		end
		// zero half period, zero ring, oversized ring, center outside ring
		set_regs(24'hFFFFFF, 16'd0, 6'd63, 7'd0);
		send_request(STYLE_FILL, 32'd1);
		send_request(STYLE_RIPPLE, 32'hAAAA_5555);
		set_regs(24'h123456, 16'd65535, 6'd63, 7'd127);
		for (int s = 0; s < 4; s++) send_request(style_t'(s), 32'd100000);
		set_regs(24'h000000, 16'd1, 6'd40, 7'd5);
		for (int s = 0; s < 4; s++) send_request(style_t'(s), 32'd3);
		set_regs(24'hFFFFFF, 16'd7, 6'd0, 7'd64);
		send_request(STYLE_SPIN, 32'd13);

		// random phases over pacing and register settings
		for (int p = 0; p < 16; p++) begin
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 70; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 70; end
				default: begin send_idle = 13; recv_stall = 13; end
			endcase
			half = (p % 5 == 0) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 40));
			ring = (p % 6 == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 24));
			set_regs(24'($urandom()), half, 6'($urandom_range(63)), ring);
			for (int k = 0; k < 27; k++)
				send_request(style_t'($urandom_range(3)), rand_elapsed(half));
		end
		send_idle = 0;
		recv_stall = 0;
		drain();
		$display("covered %0d frame requests and %0d LED colors over four styles",
			frame_count, led_count);
		$display("register settings varied across color, period, center and ring extremes");
		if (fail_count == 0 && pending_leds == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/lref_pkg.sv
rtl/core/lref_intf.sv
rtl/core/lref_frame_setup.sv
rtl/core/lref_pixel_pipe.sv
rtl/core/led_ring_effect_frame.sv
rtl/core/lref_checker.sv
tb/led_ring_effect_frame_checker.sv
tb/tb.sv
